FILE: sv/sit_pkg.sv
package sit_pkg;

    // Fixed field widths
    localparam int REG_W      = 5;
    localparam int ID_W       = 4;
    localparam int LAT_W      = 4;
    localparam int STAT_W     = 2;
    localparam int CLS_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int MASK_OUT_W = 9;

    // Operation codes
    localparam logic OP_ISSUE = 1'b0;
    localparam logic OP_WB    = 1'b1;

    // Unit classes; the code above memory also maps to memory
    localparam logic [CLS_W-1:0] CLS_ALU = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MUL = 2'd1;
    localparam logic [CLS_W-1:0] CLS_MEM = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_PENDING = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALU_LAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUL_LAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LAT = 2'd2;

    // Latency register reset values
    localparam logic [LAT_W-1:0] ALU_LAT_RESET = 4'd0;
    localparam logic [LAT_W-1:0] MUL_LAT_RESET = 4'd5;
    localparam logic [LAT_W-1:0] MEM_LAT_RESET = 4'd0;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input beat
        logic commit;   // update the scoreboard and the result register
    } t_dp_cmd;

endpackage

FILE: sv/scoreboard_issue_tracker_unit.sv
// A result is written to the result register at the commit that follows the
// capture of its input beat; the commit waits while the output register still
// holds an unaccepted result. With the single capture register, a new beat is
// taken only after the last one commits, and a pending result waits while the
// next beat is taken. Reset (i_rst_n, synchronous, active low): all units free,
// all tags clear, latencies back to ALU 0, MUL 5, MEM 0.
module scoreboard_issue_tracker_unit
    import sit_pkg::*;
#(
    parameter int ALU_UNITS = 4,
    parameter int MUL_UNITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_operation,
    input  logic [CLS_W-1:0]      i_unit_class,
    input  logic [REG_W-1:0]      i_dest_reg,
    input  logic [REG_W-1:0]      i_src1_reg,
    input  logic [REG_W-1:0]      i_src2_reg,
    input  logic [ID_W-1:0]       i_unit_id,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STAT_W-1:0]     o_issue_status,
    output logic [ID_W-1:0]       o_granted_unit,
    output logic [ID_W-1:0]       o_src1_producer,
    output logic [ID_W-1:0]       o_src2_producer,
    output logic [LAT_W-1:0]      o_exec_cycles,
    output logic [REG_W-1:0]      o_released_reg,
    output logic [MASK_OUT_W-1:0] o_ready_mask,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LAT_W-1:0]      i_cfg_data
);

    t_dp_cmd cmd;

    // Config writes are always accepted
    assign o_cfg_ready = 1'b1;

    sit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    sit_dpath #(
        .ALU_UNITS (ALU_UNITS),
        .MUL_UNITS (MUL_UNITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_unit_class    (i_unit_class),
        .i_dest_reg      (i_dest_reg),
        .i_src1_reg      (i_src1_reg),
        .i_src2_reg      (i_src2_reg),
        .i_unit_id       (i_unit_id),
        .o_issue_status  (o_issue_status),
        .o_granted_unit  (o_granted_unit),
        .o_src1_producer (o_src1_producer),
        .o_src2_producer (o_src2_producer),
        .o_exec_cycles   (o_exec_cycles),
        .o_released_reg  (o_released_reg),
        .o_ready_mask    (o_ready_mask)
    );

endmodule

FILE: sv/sit_ctrl.sv
module sit_ctrl
    import sit_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // commit only when the result register is free or draining
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit while result register still occupied");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted beat did not start execution");

    a_commit_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_out_valid && r_state == S_IDLE))
        else $error("committed result not presented");
`endif

endmodule

FILE: sv/sit_dpath.sv
module sit_dpath
    import sit_pkg::*;
#(
    parameter int ALU_UNITS = 4,
    parameter int MUL_UNITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LAT_W-1:0]      i_cfg_data,
    input  logic                  i_operation,
    input  logic [CLS_W-1:0]      i_unit_class,
    input  logic [REG_W-1:0]      i_dest_reg,
    input  logic [REG_W-1:0]      i_src1_reg,
    input  logic [REG_W-1:0]      i_src2_reg,
    input  logic [ID_W-1:0]       i_unit_id,
    output logic [STAT_W-1:0]     o_issue_status,
    output logic [ID_W-1:0]       o_granted_unit,
    output logic [ID_W-1:0]       o_src1_producer,
    output logic [ID_W-1:0]       o_src2_producer,
    output logic [LAT_W-1:0]      o_exec_cycles,
    output logic [REG_W-1:0]      o_released_reg,
    output logic [MASK_OUT_W-1:0] o_ready_mask
);

    localparam int NUM_UNITS = ALU_UNITS + MUL_UNITS + 1;
    localparam int TAG_W     = $clog2(NUM_UNITS + 1);
    localparam int MASK_W    = (NUM_UNITS > MASK_OUT_W) ? NUM_UNITS : MASK_OUT_W;

    // Unit table; entry i holds unit i+1
    logic [NUM_UNITS-1:0] r_busy, n_busy;
    logic [REG_W-1:0]     r_dest   [NUM_UNITS];
    logic [REG_W-1:0]     n_dest   [NUM_UNITS];
    logic [TAG_W-1:0]     r_wait_a [NUM_UNITS];
    logic [TAG_W-1:0]     n_wait_a [NUM_UNITS];
    logic [TAG_W-1:0]     r_wait_b [NUM_UNITS];
    logic [TAG_W-1:0]     n_wait_b [NUM_UNITS];

    // Latency registers
    logic [LAT_W-1:0] r_alu_lat, r_mul_lat, r_mem_lat;

    // Captured input beat
    logic             r_op;
    logic [CLS_W-1:0] r_cls;
    logic [REG_W-1:0] r_dreg, r_s1reg, r_s2reg;
    logic [ID_W-1:0]  r_uid;

    // Result register
    logic [STAT_W-1:0]     r_status, n_status;
    logic [ID_W-1:0]       r_grant, n_grant;
    logic [ID_W-1:0]       r_p1, n_p1;
    logic [ID_W-1:0]       r_p2, n_p2;
    logic [LAT_W-1:0]      r_cyc, n_cyc;
    logic [REG_W-1:0]      r_rel, n_rel;
    logic [MASK_OUT_W-1:0] r_ready, n_ready;

    // Working signals
    logic [NUM_UNITS-1:0] cls_mask, free_v, pick, wb_hit;
    logic [LAT_W-1:0]     cls_lat;
    logic [TAG_W-1:0]     p1_tag, p2_tag, grant_tag;
    logic [REG_W-1:0]     rel_reg;
    logic                 dest_pend, found, issue_ok, wb_any;
    logic [MASK_W-1:0]    mask_full;

    // Units of the requested class and its latency
    always_comb begin
        for (int i = 0; i < NUM_UNITS; i++) begin
            case (r_cls)
                CLS_ALU: cls_mask[i] = (i < ALU_UNITS);
                CLS_MUL: cls_mask[i] = (i >= ALU_UNITS) && (i < ALU_UNITS + MUL_UNITS);
                default: cls_mask[i] = (i == NUM_UNITS - 1);
            endcase
        end
        case (r_cls)
            CLS_ALU: cls_lat = r_alu_lat;
            CLS_MUL: cls_lat = r_mul_lat;
            default: cls_lat = r_mem_lat;
        endcase
    end

    // Lowest free unit of the class: isolate the lowest set bit
    assign free_v = cls_mask & ~r_busy;
    assign pick   = free_v & (~free_v + 1'b1);
    assign found  = |free_v;

    // Producer lookup: a register's producer is the busy unit whose
    // destination it is (at most one, since issue stalls on a pending dest)
    always_comb begin
        p1_tag    = '0;
        p2_tag    = '0;
        grant_tag = '0;
        rel_reg   = '0;
        dest_pend = 1'b0;
        for (int i = 0; i < NUM_UNITS; i++) begin
            if (r_busy[i] && r_dest[i] == r_s1reg) p1_tag = p1_tag | TAG_W'(i + 1);
            if (r_busy[i] && r_dest[i] == r_s2reg) p2_tag = p2_tag | TAG_W'(i + 1);
            if (r_busy[i] && r_dest[i] == r_dreg)  dest_pend = 1'b1;
            if (pick[i])                            grant_tag = grant_tag | TAG_W'(i + 1);
            wb_hit[i] = (r_op == OP_WB) && (int'(r_uid) == i + 1);
            if (wb_hit[i])                          rel_reg = rel_reg | r_dest[i];
        end
    end

    assign wb_any   = |wb_hit;
    assign issue_ok = (r_op == OP_ISSUE) && found && !dest_pend;

    // Next unit table
    always_comb begin
        for (int i = 0; i < NUM_UNITS; i++) begin
            n_busy[i]   = r_busy[i];
            n_dest[i]   = r_dest[i];
            n_wait_a[i] = r_wait_a[i];
            n_wait_b[i] = r_wait_b[i];
            if (issue_ok && pick[i]) begin
                n_busy[i]   = 1'b1;
                n_dest[i]   = r_dreg;
                n_wait_a[i] = p1_tag;
                n_wait_b[i] = p2_tag;
            end
            if (wb_hit[i]) begin
                n_busy[i] = 1'b0;
            end
            // release every wait on the finishing unit
            if (wb_any && int'(r_wait_a[i]) == int'(r_uid)) n_wait_a[i] = '0;
            if (wb_any && int'(r_wait_b[i]) == int'(r_uid)) n_wait_b[i] = '0;
        end
    end

    // Next result
    always_comb begin
        if (r_op == OP_ISSUE && !found) begin
            n_status = ST_NOFREE;
        end else if (r_op == OP_ISSUE && dest_pend) begin
            n_status = ST_PENDING;
        end else begin
            n_status = ST_OK;
        end
        n_grant = issue_ok ? ID_W'(grant_tag) : '0;
        n_p1    = issue_ok ? ID_W'(p1_tag) : '0;
        n_p2    = issue_ok ? ID_W'(p2_tag) : '0;
        n_cyc   = issue_ok ? cls_lat : '0;
        n_rel   = rel_reg;
        // ready mask taken after the update
        mask_full = '0;
        for (int i = 0; i < NUM_UNITS; i++) begin
            mask_full[i] = n_busy[i] && (n_wait_a[i] == '0) && (n_wait_b[i] == '0);
        end
        n_ready = mask_full[MASK_OUT_W-1:0];
    end

    // Unit table and latency registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_alu_lat <= ALU_LAT_RESET;
            r_mul_lat <= MUL_LAT_RESET;
            r_mem_lat <= MEM_LAT_RESET;
            for (int i = 0; i < NUM_UNITS; i++) begin
                r_dest[i]   <= '0;
                r_wait_a[i] <= '0;
                r_wait_b[i] <= '0;
            end
        end else begin
            if (i_cmd.commit) begin
                r_busy <= n_busy;
                for (int i = 0; i < NUM_UNITS; i++) begin
                    r_dest[i]   <= n_dest[i];
                    r_wait_a[i] <= n_wait_a[i];
                    r_wait_b[i] <= n_wait_b[i];
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALU_LAT: r_alu_lat <= i_cfg_data;
                    CFG_MUL_LAT: r_mul_lat <= i_cfg_data;
                    CFG_MEM_LAT: r_mem_lat <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Input beat and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_cls   <= i_unit_class;
            r_dreg  <= i_dest_reg;
            r_s1reg <= i_src1_reg;
            r_s2reg <= i_src2_reg;
            r_uid   <= i_unit_id;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_grant  <= n_grant;
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_cyc    <= n_cyc;
            r_rel    <= n_rel;
            r_ready  <= n_ready;
        end
    end

    assign o_issue_status  = r_status;
    assign o_granted_unit  = r_grant;
    assign o_src1_producer = r_p1;
    assign o_src2_producer = r_p2;
    assign o_exec_cycles   = r_cyc;
    assign o_released_reg  = r_rel;
    assign o_ready_mask    = r_ready;

endmodule

FILE: verif/sit_checker.sv
`timescale 1ns / 1ps

// Watches the issue, result and register channels of the issue tracker,
// keeps its own copy of the unit and register tags, and compares every
// result beat with the outcome worked out for the matching input beat.
module sit_checker
    import sit_pkg::*;
#(
    parameter int ALU_UNITS = 4,
    parameter int MUL_UNITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_operation,
    input  logic [CLS_W-1:0]      i_unit_class,
    input  logic [REG_W-1:0]      i_dest_reg,
    input  logic [REG_W-1:0]      i_src1_reg,
    input  logic [REG_W-1:0]      i_src2_reg,
    input  logic [ID_W-1:0]       i_unit_id,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [STAT_W-1:0]     i_issue_status,
    input  logic [ID_W-1:0]       i_granted_unit,
    input  logic [ID_W-1:0]       i_src1_producer,
    input  logic [ID_W-1:0]       i_src2_producer,
    input  logic [LAT_W-1:0]      i_exec_cycles,
    input  logic [REG_W-1:0]      i_released_reg,
    input  logic [MASK_OUT_W-1:0] i_ready_mask,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LAT_W-1:0]      i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    localparam int UNITS = ALU_UNITS + MUL_UNITS + 1;
    localparam int REGS  = 1 << REG_W;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [ID_W-1:0]       grant;
        logic [ID_W-1:0]       src1_tag;
        logic [ID_W-1:0]       src2_tag;
        logic [LAT_W-1:0]      cycles;
        logic [REG_W-1:0]      released;
        logic [MASK_OUT_W-1:0] mask;
    } t_outcome;

    // Shadow scoreboard
    logic             busy     [1:UNITS];
    logic [REG_W-1:0] unit_dst [1:UNITS];
    logic [ID_W-1:0]  wait_a   [1:UNITS];
    logic [ID_W-1:0]  wait_b   [1:UNITS];
    logic [ID_W-1:0]  reg_tag  [0:REGS-1];
    logic [LAT_W-1:0] alu_lat;
    logic [LAT_W-1:0] mul_lat;
    logic [LAT_W-1:0] mem_lat;

    t_outcome outcome_q [$];
    t_outcome want;
    t_outcome got;
    int       mismatches = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // Apply one issue or write-back to the shadow board, return its result
    function automatic t_outcome board_step(
        input logic             op,
        input logic [CLS_W-1:0] cls,
        input logic [REG_W-1:0] dst,
        input logic [REG_W-1:0] s1,
        input logic [REG_W-1:0] s2,
        input logic [ID_W-1:0]  uid
    );
        t_outcome         res;
        int               first;
        int               last;
        int               pick;
        int               u;
        logic [LAT_W-1:0] lat;
        logic [REG_W-1:0] rel;
        res = '0;
        if (op == OP_ISSUE) begin
            case (cls)
                CLS_ALU: begin
                    first = 1;
                    last  = ALU_UNITS;
                    lat   = alu_lat;
                end
                CLS_MUL: begin
                    first = ALU_UNITS + 1;
                    last  = ALU_UNITS + MUL_UNITS;
                    lat   = mul_lat;
                end
                // memory, and the unused class code as memory
                default: begin
                    first = UNITS;
                    last  = UNITS;
                    lat   = mem_lat;
                end
            endcase
            pick = 0;
            for (u = first; u <= last; u++) begin
                if (pick == 0 && !busy[u])
                    pick = u;
            end
            if (pick == 0) begin
                res.status = ST_NOFREE;
            end else if (reg_tag[dst] != '0) begin
                res.status = ST_PENDING;
            end else begin
                res.status   = ST_OK;
                res.src1_tag = reg_tag[s1];
                res.src2_tag = reg_tag[s2];
                res.grant    = ID_W'(pick);
                res.cycles   = lat;
                busy[pick]     = 1'b1;
                unit_dst[pick] = dst;
                wait_a[pick]   = res.src1_tag;
                wait_b[pick]   = res.src2_tag;
                reg_tag[dst]   = ID_W'(pick);
            end
        end else if (uid >= 1 && uid <= UNITS) begin
            // idle units release their last destination too
            res.status = ST_OK;
            rel = unit_dst[uid];
            busy[uid] = 1'b0;
            if (reg_tag[rel] == uid)
                reg_tag[rel] = '0;
            for (u = 1; u <= UNITS; u++) begin
                if (wait_a[u] == uid)
                    wait_a[u] = '0;
                if (wait_b[u] == uid)
                    wait_b[u] = '0;
            end
            res.released = rel;
        end else begin
            res.status = ST_OK;
        end
        // units busy with both operands ready, after the update
        for (u = 1; u <= UNITS; u++) begin
            if (busy[u] && wait_a[u] == '0 && wait_b[u] == '0)
                res.mask[u-1] = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        int u;
        if (!i_rst_n) begin
            for (u = 1; u <= UNITS; u++) begin
                busy[u]     = 1'b0;
                unit_dst[u] = '0;
                wait_a[u]   = '0;
                wait_b[u]   = '0;
            end
            for (u = 0; u < REGS; u++)
                reg_tag[u] = '0;
            alu_lat = ALU_LAT_RESET;
            mul_lat = MUL_LAT_RESET;
            mem_lat = MEM_LAT_RESET;
            outcome_q.delete();
        end else begin
            // result beat against the oldest outstanding outcome
            if (i_out_valid && i_out_ready) begin
                got.status   = i_issue_status;
                got.grant    = i_granted_unit;
                got.src1_tag = i_src1_producer;
                got.src2_tag = i_src2_producer;
                got.cycles   = i_exec_cycles;
                got.released = i_released_reg;
                got.mask     = i_ready_mask;
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing outstanding", $realtime);
                end else begin
                    want = outcome_q.pop_front();
                    if (want != got) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp st=%0d gr=%0d p1=%0d p2=%0d ",
                                      "cyc=%0d rel=%0d mask=%03h act st=%0d gr=%0d ",
                                      "p1=%0d p2=%0d cyc=%0d rel=%0d mask=%03h"},
                                     $realtime, want.status, want.grant, want.src1_tag,
                                     want.src2_tag, want.cycles, want.released, want.mask,
                                     got.status, got.grant, got.src1_tag, got.src2_tag,
                                     got.cycles, got.released, got.mask);
                    end
                end
            end
            // latency register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ALU_LAT: alu_lat = i_cfg_data;
                    CFG_MUL_LAT: mul_lat = i_cfg_data;
                    CFG_MEM_LAT: mem_lat = i_cfg_data;
                    default: ;
                endcase
            end
            // input beat
            if (i_in_valid && i_in_ready)
                outcome_q.push_back(board_step(i_operation, i_unit_class, i_dest_reg,
                                               i_src1_reg, i_src2_reg, i_unit_id));
        end
        o_fail_count  <= mismatches;
        o_outstanding <= outcome_q.size();
    end

endmodule

FILE: verif/tb_scoreboard_issue_tracker_unit.sv
`timescale 1ns / 1ps

module tb_scoreboard_issue_tracker_unit;
    import sit_pkg::*;

    localparam int ALU_UNITS   = 4;
    localparam int MUL_UNITS   = 4;
    localparam int UNITS       = ALU_UNITS + MUL_UNITS + 1;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASES      = 4;

    // class code with no class of its own, and the empty unit id
    localparam logic [CLS_W-1:0] CLS_SPARE = 2'd3;
    localparam logic [ID_W-1:0]  NO_UNIT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  operation = OP_ISSUE;
    logic [CLS_W-1:0]      unit_class = '0;
    logic [REG_W-1:0]      dest_reg  = '0;
    logic [REG_W-1:0]      src1_reg  = '0;
    logic [REG_W-1:0]      src2_reg  = '0;
    logic [ID_W-1:0]       unit_id   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STAT_W-1:0]     issue_status;
    logic [ID_W-1:0]       granted_unit;
    logic [ID_W-1:0]       src1_producer;
    logic [ID_W-1:0]       src2_producer;
    logic [LAT_W-1:0]      exec_cycles;
    logic [REG_W-1:0]      released_reg;
    logic [MASK_OUT_W-1:0] ready_mask;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [LAT_W-1:0]      cfg_data  = '0;
    int                    fail_count;
    int                    outstanding;

    int gap_ahead  = 0;
    bit eager_send = 1'b0;

    scoreboard_issue_tracker_unit #(
        .ALU_UNITS(ALU_UNITS),
        .MUL_UNITS(MUL_UNITS)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_operation(operation),
        .i_unit_class(unit_class),
        .i_dest_reg(dest_reg),
        .i_src1_reg(src1_reg),
        .i_src2_reg(src2_reg),
        .i_unit_id(unit_id),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_issue_status(issue_status),
        .o_granted_unit(granted_unit),
        .o_src1_producer(src1_producer),
        .o_src2_producer(src2_producer),
        .o_exec_cycles(exec_cycles),
        .o_released_reg(released_reg),
        .o_ready_mask(ready_mask),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    sit_checker #(
        .ALU_UNITS(ALU_UNITS),
        .MUL_UNITS(MUL_UNITS)
    ) u_sit_checker (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_ready(in_ready),
        .i_operation(operation),
        .i_unit_class(unit_class),
        .i_dest_reg(dest_reg),
        .i_src1_reg(src1_reg),
        .i_src2_reg(src2_reg),
        .i_unit_id(unit_id),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_issue_status(issue_status),
        .i_granted_unit(granted_unit),
        .i_src1_producer(src1_producer),
        .i_src2_producer(src2_producer),
        .i_exec_cycles(exec_cycles),
        .i_released_reg(released_reg),
        .i_ready_mask(ready_mask),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_fail_count(fail_count),
        .o_outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len(input bit eager);
        int r;
        if (eager)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Register numbers lean toward a few so dependencies and conflicts occur
    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(0, 9) < 6)
            return REG_W'($urandom_range(0, 7));
        return REG_W'($urandom_range(0, 31));
    endfunction

    // One input beat; valid drops only when the next beat waits
    task automatic send_beat(
        input logic             op,
        input logic [CLS_W-1:0] cls,
        input logic [REG_W-1:0] dst,
        input logic [REG_W-1:0] s1,
        input logic [REG_W-1:0] s2,
        input logic [ID_W-1:0]  uid
    );
        if (gap_ahead > 0)
            repeat (gap_ahead) @(posedge clk);
        in_valid   <= 1'b1;
        operation  <= op;
        unit_class <= cls;
        dest_reg   <= dst;
        src1_reg   <= s1;
        src2_reg   <= s2;
        unit_id    <= uid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap_ahead = idle_len(eager_send);
        if (gap_ahead > 0)
            in_valid <= 1'b0;
    endtask

    task automatic issue_op(
        input logic [CLS_W-1:0] cls,
        input logic [REG_W-1:0] dst,
        input logic [REG_W-1:0] s1,
        input logic [REG_W-1:0] s2
    );
        send_beat(OP_ISSUE, cls, dst, s1, s2, ID_W'($urandom));
    endtask

    task automatic retire_op(input logic [ID_W-1:0] uid);
        send_beat(OP_WB, CLS_W'($urandom), REG_W'($urandom), REG_W'($urandom),
                  REG_W'($urandom), uid);
    endtask

    // Stop offering beats and wait until every result has come back
    task automatic settle();
        if (gap_ahead == 0)
            in_valid <= 1'b0;
        gap_ahead = 0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Directed: fill the ALUs, hit both stalls, odd ids, idle write-back
    task automatic run_directed();
        issue_op(CLS_ALU, 5'd1, 5'd0, 5'd0);
        issue_op(CLS_ALU, 5'd2, 5'd1, 5'd1);
        issue_op(CLS_ALU, 5'd1, 5'd2, 5'd2);
        issue_op(CLS_ALU, 5'd3, 5'd31, 5'd2);
        issue_op(CLS_ALU, 5'd4, 5'd3, 5'd0);
        issue_op(CLS_ALU, 5'd1, 5'd0, 5'd0);
        issue_op(CLS_MUL, 5'd31, 5'd4, 5'd3);
        issue_op(CLS_MEM, 5'd0, 5'd31, 5'd0);
        issue_op(CLS_SPARE, 5'd6, 5'd0, 5'd0);
        retire_op(NO_UNIT);
        retire_op(4'd15);
        retire_op(4'd10);
        retire_op(4'd1);
        retire_op(4'd1);
        retire_op(4'd9);
        issue_op(CLS_SPARE, 5'd7, 5'd0, 5'd31);
        issue_op(CLS_MUL, 5'd0, 5'd7, 5'd31);
        retire_op(4'd2);
        retire_op(4'd3);
        retire_op(4'd4);
        retire_op(4'd5);
        retire_op(4'd6);
        retire_op(4'd7);
        retire_op(4'd8);
        retire_op(4'd9);
    endtask

    // Random beat; out-of-range write-backs are not counted
    task automatic random_item(output bit counted);
        int               r;
        logic [CLS_W-1:0] cls;
        logic [ID_W-1:0]  uid;
        r = $urandom_range(0, 99);
        counted = 1'b1;
        if (r < 55) begin
            cls = ($urandom_range(0, 19) == 0) ? CLS_SPARE : CLS_W'($urandom_range(0, 2));
            issue_op(cls, pick_reg(), pick_reg(), pick_reg());
        end else if (r < 95) begin
            retire_op(ID_W'($urandom_range(1, UNITS)));
        end else begin
            r = $urandom_range(0, 6);
            uid = (r == 0) ? NO_UNIT : ID_W'(UNITS + r);
            retire_op(uid);
            counted = 1'b0;
        end
    endtask

    // Result side: random stalls, one long hold-off once traffic is flowing
    initial begin : drain_side
        int hold;
        int beats;
        bit squeezed;
        bit eager_recv;
        beats = 0;
        squeezed = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever begin
            eager_recv = ($urandom_range(0, 4) == 0);
            if (!squeezed && beats >= 150) begin
                squeezed = 1'b1;
                hold = 300;
            end else begin
                hold = idle_len(eager_recv);
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) begin
                @(posedge clk);
                if (out_valid && out_ready)
                    beats++;
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int  done_items;
        int  phase;
        int  waited;
        bit  counted;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset latencies first
        run_directed();

        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_reg(CFG_ALU_LAT, 4'd15);
                    write_reg(CFG_MUL_LAT, 4'd15);
                    write_reg(CFG_MEM_LAT, 4'd15);
                end
                1: begin
                    write_reg(CFG_ALU_LAT, 4'd0);
                    write_reg(CFG_MUL_LAT, 4'd0);
                    write_reg(CFG_MEM_LAT, 4'd0);
                    write_reg(CFG_UNUSED, LAT_W'($urandom));
                end
                default: begin
                    write_reg(CFG_ALU_LAT, LAT_W'($urandom));
                    write_reg(CFG_MUL_LAT, LAT_W'($urandom));
                    write_reg(CFG_MEM_LAT, LAT_W'($urandom));
                end
            endcase
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                if (done_items % 50 == 0)
                    eager_send = ($urandom_range(0, 3) == 0);
                random_item(counted);
                done_items += counted;
            end
        end

        // wait for the last results, bounded
        if (gap_ahead == 0)
            in_valid <= 1'b0;
        gap_ahead = 0;
        waited = 0;
        repeat (2) @(posedge clk);
        while (outstanding != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
